// ----- design/b64u_pkg.sv -----
// Shared types and constants for the URL-safe base64 decoder.
// No dependencies; imported by b64u_group, b64u_serial and base64url_decoder.
`default_nettype none

package b64u_pkg;

    // Padding character '='
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Alphabet characters outside the letter and digit ranges
    localparam logic [7:0] DASH_CHAR  = 8'h2D;
    localparam logic [7:0] UNDER_CHAR = 8'h5F;
    localparam logic [5:0] DASH_VAL   = 6'h3E;
    localparam logic [5:0] UNDER_VAL  = 6'h3F;

    // Decoded character: 6-bit value plus a flag for bytes outside the alphabet
    typedef struct packed {
        logic       bad;
        logic [5:0] val;
    } sextet_t;

    // One decoded group on its way to the output: up to three bytes, MSB first
    typedef struct packed {
        logic [23:0] data;
        logic [1:0]  count;
        logic        last;
        logic        bad;
    } group_rec_t;

    // Map one character to its sextet; an invalid byte reads as all ones
    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t s;
        s.bad = 1'b0;
        s.val = 6'h3F;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            s.val = 6'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            s.val = 6'(c - 8'd71);
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            s.val = 6'(c + 8'd4);
        end
        else if (c == DASH_CHAR)
        begin
            s.val = DASH_VAL;
        end
        else if (c == UNDER_CHAR)
        begin
            s.val = UNDER_VAL;
        end
        else
        begin
            s.bad = 1'b1;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- design/b64u_group.sv -----
// Group assembler: holds the sextet accumulator and string state, and
// builds one group record per completed group or final character. Uses b64u_pkg.
`default_nettype none

module b64u_group
    import b64u_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] char_in,
    input  wire logic       is_final,
    input  wire logic       slot_free,
    output logic            rec_push,
    output group_rec_t      rec
);

    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_FOURTH = 2'd3;

    logic [17:0] acc_reg, acc_next;
    logic [1:0]  pos_reg, pos_next;
    logic        pad3_reg, pad3_next;
    logic        err_reg, err_next;

    sextet_t     sx;
    logic        is_pad;
    logic        bad_now;
    logic        err_now;
    logic [17:0] acc_step;
    logic        pad3_step;
    logic [1:0]  nbytes;
    logic [23:0] full;
    logic        needs_slot;
    logic        accept;

    // Decode the character and work out this position's contribution
    always_comb
    begin
        sx        = sextet_of(char_in);
        is_pad    = (char_in == PAD_CHAR);
        bad_now   = 1'b0;
        acc_step  = acc_reg;
        pad3_step = pad3_reg;
        nbytes    = 2'd0;
        full      = 24'd0;
        unique case (pos_reg)
            POS_FIRST:
            begin
                bad_now  = sx.bad | is_final;
                acc_step = {12'd0, sx.val};
            end
            POS_SECOND:
            begin
                bad_now  = sx.bad;
                acc_step = {acc_reg[11:0], sx.val};
                nbytes   = 2'd1;
                full     = {acc_reg[5:0], sx.val, 12'd0};
            end
            POS_THIRD:
            begin
                if (is_pad)
                begin
                    pad3_step = 1'b1;
                    acc_step  = {acc_reg[11:0], 6'd0};
                    bad_now   = is_final;
                end
                else
                begin
                    bad_now  = sx.bad;
                    acc_step = {acc_reg[11:0], sx.val};
                    nbytes   = 2'd2;
                    full     = {acc_reg[11:0], sx.val, 6'd0};
                end
            end
            POS_FOURTH:
            begin
                if (is_pad)
                begin
                    bad_now = !is_final;
                    nbytes  = pad3_reg ? 2'd1 : 2'd2;
                    full    = {acc_reg, 6'd0};
                end
                else
                begin
                    bad_now = sx.bad | pad3_reg;
                    nbytes  = 2'd3;
                    full    = {acc_reg, sx.val};
                end
            end
            default:
            begin
                bad_now = 1'b1;
            end
        endcase
        err_now = err_reg | bad_now;
    end

    // Build the record: a single error result closes a bad string
    always_comb
    begin
        needs_slot = is_final || (pos_reg == POS_FOURTH);
        rec_push   = accept && (is_final || (pos_reg == POS_FOURTH && !err_now));
        if (is_final && err_now)
        begin
            rec.data  = 24'd0;
            rec.count = 2'd1;
            rec.last  = 1'b1;
            rec.bad   = 1'b1;
        end
        else
        begin
            rec.data  = full;
            rec.count = nbytes;
            rec.last  = is_final;
            rec.bad   = 1'b0;
        end
    end

    // Stall only characters that may produce output while the slot is busy
    assign in_ready = slot_free || !needs_slot;
    assign accept   = in_valid && in_ready;

    // Advance string state; clear it after a final character
    always_comb
    begin
        acc_next  = acc_reg;
        pos_next  = pos_reg;
        pad3_next = pad3_reg;
        err_next  = err_reg;
        if (accept)
        begin
            if (is_final)
            begin
                acc_next  = 18'd0;
                pos_next  = POS_FIRST;
                pad3_next = 1'b0;
                err_next  = 1'b0;
            end
            else
            begin
                pos_next = pos_reg + 2'd1;
                err_next = err_now;
                if (pos_reg == POS_FOURTH)
                begin
                    acc_next  = 18'd0;
                    pad3_next = 1'b0;
                end
                else
                begin
                    acc_next  = acc_step;
                    pad3_next = pad3_step;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= 18'd0;
            pos_reg  <= POS_FIRST;
            pad3_reg <= 1'b0;
            err_reg  <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            pos_reg  <= pos_next;
            pad3_reg <= pad3_next;
            err_reg  <= err_next;
        end
    end

    // A record is only pushed into a free slot
    assert property (@(posedge clk) disable iff (!rst_n) rec_push |-> slot_free)
        else $error("group record pushed while output slot busy");

    // A final character leaves the string state cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_final) |=> (pos_reg == POS_FIRST && !err_reg && !pad3_reg))
        else $error("string state not cleared after final character");

    // A pushed record always carries at least one byte
    assert property (@(posedge clk) disable iff (!rst_n) rec_push |-> rec.count != 2'd0)
        else $error("empty group record pushed");

endmodule

`default_nettype wire

// ----- design/b64u_serial.sv -----
// Output serializer: holds one group record and hands out its bytes one
// transaction at a time, most significant first. Uses b64u_pkg.
`default_nettype none

module b64u_serial
    import b64u_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       rec_push,
    input  group_rec_t      rec,
    output logic            slot_free,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      byte_out,
    output logic            end_of_run,
    output logic            bad_input
);

    logic        valid_reg, valid_next;
    logic [1:0]  idx_reg, idx_next;
    group_rec_t  rec_reg, rec_next;

    logic        is_last;
    logic        pop;

    assign is_last   = (idx_reg == rec_reg.count - 2'd1);
    assign pop       = valid_reg && out_ready;
    assign slot_free = !valid_reg || (pop && is_last);

    // Select the current byte of the held group
    always_comb
    begin
        unique case (idx_reg)
            2'd0:    byte_out = rec_reg.data[23:16];
            2'd1:    byte_out = rec_reg.data[15:8];
            default: byte_out = rec_reg.data[7:0];
        endcase
    end

    assign out_valid  = valid_reg;
    assign end_of_run = rec_reg.last && is_last;
    assign bad_input  = rec_reg.bad;

    // Load a new record, or advance through the held one
    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        rec_next   = rec_reg;
        if (rec_push)
        begin
            valid_next = 1'b1;
            idx_next   = 2'd0;
            rec_next   = rec;
        end
        else if (pop)
        begin
            if (is_last)
            begin
                valid_next = 1'b0;
                idx_next   = 2'd0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // Payload holds no reset
    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    // Byte index never runs past the record's byte count
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (idx_reg < rec_reg.count))
        else $error("byte index beyond record count");

    // An error record is always a single closing byte of zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && rec_reg.bad) |-> (rec_reg.last && rec_reg.count == 2'd1
                                         && byte_out == 8'd0))
        else $error("malformed error record");

    // Taking a non-last byte keeps the slot occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !is_last && !rec_push) |=> valid_reg)
        else $error("record dropped before its last byte");

endmodule

`default_nettype wire

// ----- design/base64url_decoder.sv -----
// URL-safe base64 decoder, top level.
// Instantiates b64u_group and b64u_serial; uses b64u_pkg.
//
// Input channel (in_valid/in_ready): one character per transaction on
// char_in, with is_final set on the last character of a string.
// Output channel (out_valid/out_ready): one decoded byte per transaction on
// byte_out; end_of_run marks the last byte of a string and bad_input marks a
// string that must be discarded (a single zero byte closes such a string).
// The bytes of a group appear in the cycle after the character that
// completes it is taken, then leave one per cycle while out_ready is high.
// Throughput: one character per cycle while out_ready stays high, set by the
// one-group output slot draining three bytes as the next three characters are taken.
// A character that completes a group or ends a string waits while the slot
// still holds undelivered bytes; other characters are always taken.
// Reset clears the string state and empties the output slot.
// When the receiver stalls, the held byte stays on the port unchanged.
`default_nettype none

module base64url_decoder
    import b64u_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] char_in,
    input  wire logic       is_final,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      byte_out,
    output logic            end_of_run,
    output logic            bad_input
);

    logic       slot_free;
    logic       rec_push;
    group_rec_t rec;

    b64u_group u_group
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_in   (char_in),
        .is_final  (is_final),
        .slot_free (slot_free),
        .rec_push  (rec_push),
        .rec       (rec)
    );

    b64u_serial u_serial
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .rec_push   (rec_push),
        .rec        (rec),
        .slot_free  (slot_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .byte_out   (byte_out),
        .end_of_run (end_of_run),
        .bad_input  (bad_input)
    );

endmodule

`default_nettype wire
